// File: hdl/ezr_pkg.sv
// Package for the Euler XYZ vector rotator: widths, defaults and constant
// functions (arctangent table, CORDIC gain root). No dependencies.
package ezr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int ATAN_LEN          = 24;

  // Field widths of a transaction.
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  // Integer bits of a vector component between the axis rotations.
  localparam int VEC_INT_W = 18;
  // Angle accumulator: signed, pi = 2^31.
  localparam int ANG_W     = 32;

  // atan(2^-i) with pi = 2^31, rounded.
  function automatic logic [ANG_W-1:0] atan_entry(input int idx);
    logic [ANG_W-1:0] val;
    begin
      case (idx)
        0:       val = 32'd536870912;
        1:       val = 32'd316933406;
        2:       val = 32'd167458907;
        3:       val = 32'd85004756;
        4:       val = 32'd42667331;
        5:       val = 32'd21354465;
        6:       val = 32'd10679838;
        7:       val = 32'd5340245;
        8:       val = 32'd2670163;
        9:       val = 32'd1335087;
        10:      val = 32'd667544;
        11:      val = 32'd333772;
        12:      val = 32'd166886;
        13:      val = 32'd83443;
        14:      val = 32'd41722;
        15:      val = 32'd20861;
        16:      val = 32'd10430;
        17:      val = 32'd5215;
        18:      val = 32'd2608;
        19:      val = 32'd1304;
        20:      val = 32'd652;
        21:      val = 32'd326;
        22:      val = 32'd163;
        23:      val = 32'd81;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

  // floor(sqrt(P * 2^30)), P = product of (1 + 4^-i) in Q30 over n stages.
  function automatic longint unsigned gain_root(input int n);
    longint unsigned p;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    begin
      p = 64'd1 << 30;
      for (int i = 0; i < ATAN_LEN; i++) begin
        if (i < n) begin
          p = p + (p >> (2 * i));
        end
      end
      v   = p << 30;
      res = '0;
      bt  = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    end
  endfunction

endpackage

// File: hdl/ezr_delay.sv
// Plain shift line with a shared advance enable, used to keep operands
// aligned with the pipeline. No dependencies.
module ezr_delay #(
  parameter int W     = 16,
  parameter int DEPTH = 3
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// File: hdl/ezr_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on ezr_pkg (arctangent table, angle width).
module ezr_cordic_cell #(
  parameter int STAGE = 0,
  parameter int CW    = 18
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [CW-1:0]           x_i,
  input  logic signed [CW-1:0]           y_i,
  input  logic signed [ezr_pkg::ANG_W-1:0] z_i,
  input  logic                           neg_i,
  output logic signed [CW-1:0]           x_o,
  output logic signed [CW-1:0]           y_o,
  output logic signed [ezr_pkg::ANG_W-1:0] z_o,
  output logic                           neg_o
);

  import ezr_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STAGE);

  logic signed [CW-1:0]    x_q, y_q, x_d, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic                    neg_q;

  always_comb begin
    if (!z_i[ANG_W-1]) begin
      x_d = x_i - (y_i >>> STAGE);
      y_d = y_i + (x_i >>> STAGE);
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + (y_i >>> STAGE);
      y_d = y_i - (x_i >>> STAGE);
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= neg_i;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

// File: hdl/ezr_rot_unit.sv
// Three-stage plane rotation: u = c*a - s*b, w = s*a + c*b, each rounded
// half up to the vector's fixed point. Depends on ezr_pkg (widths).
module ezr_rot_unit #(
  parameter int FRAC = 16,
  parameter int CW   = 18
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [FRAC+ezr_pkg::VEC_INT_W-1:0] a_i,
  input  logic signed [FRAC+ezr_pkg::VEC_INT_W-1:0] b_i,
  input  logic signed [CW-1:0]                  c_i,
  input  logic signed [CW-1:0]                  s_i,
  output logic signed [FRAC+ezr_pkg::VEC_INT_W-1:0] u_o,
  output logic signed [FRAC+ezr_pkg::VEC_INT_W-1:0] w_o
);

  import ezr_pkg::*;

  localparam int VW = FRAC + VEC_INT_W;
  localparam int PH = CW + VEC_INT_W;   // coefficient times integer part
  localparam int PL = CW + FRAC + 1;    // coefficient times fraction part
  localparam int HW = PH + 1;
  localparam int LW = PL + 2;
  localparam int SW = HW + 1;
  localparam longint HALF_L = 64'sd1 <<< (FRAC - 1);
  localparam logic signed [LW-1:0] HALF = LW'(HALF_L);

  // Split each operand into integer and fraction parts so that every
  // multiplier stays narrow; the split is exact.
  logic signed [VEC_INT_W-1:0] ah, bh;
  logic signed [FRAC:0]        al, bl;

  assign ah = a_i[VW-1:FRAC];
  assign bh = b_i[VW-1:FRAC];
  assign al = $signed({1'b0, a_i[FRAC-1:0]});
  assign bl = $signed({1'b0, b_i[FRAC-1:0]});

  logic signed [PH-1:0] ca_h_q, sb_h_q, sa_h_q, cb_h_q;
  logic signed [PL-1:0] ca_l_q, sb_l_q, sa_l_q, cb_l_q;
  logic signed [HW-1:0] hi_u_q, hi_w_q;
  logic signed [LW-1:0] lo_u_q, lo_w_q;
  logic signed [SW-1:0] u_sum, w_sum;
  logic signed [VW-1:0] u_q, w_q;

  assign u_sum = SW'(hi_u_q) + SW'(lo_u_q >>> FRAC);
  assign w_sum = SW'(hi_w_q) + SW'(lo_w_q >>> FRAC);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products
      ca_h_q <= c_i * ah;
      sb_h_q <= s_i * bh;
      sa_h_q <= s_i * ah;
      cb_h_q <= c_i * bh;
      ca_l_q <= c_i * al;
      sb_l_q <= s_i * bl;
      sa_l_q <= s_i * al;
      cb_l_q <= c_i * bl;
      // integer and fraction sums
      hi_u_q <= HW'(ca_h_q) - HW'(sb_h_q);
      hi_w_q <= HW'(sa_h_q) + HW'(cb_h_q);
      lo_u_q <= LW'(ca_l_q) - LW'(sb_l_q) + HALF;
      lo_w_q <= LW'(sa_l_q) + LW'(cb_l_q) + HALF;
      // merge
      u_q    <= u_sum[VW-1:0];
      w_q    <= w_sum[VW-1:0];
    end
  end

  assign u_o = u_q;
  assign w_o = w_q;

endmodule

// File: hdl/euler_xyz_vector_rotator_core.sv
// Top level of the Euler XYZ vector rotator: CORDIC cell chain, three plane
// rotations and the output skid. Depends on ezr_pkg and all ezr_* modules.
//
// Rotates a 16-bit integer vector about x, then y, then z (out = Rz*Ry*Rx*v)
// by three binary angles (value/32768 * pi radians) and returns each
// component rounded half up to an 18-bit signed integer; rotation keeps
// length, so nothing saturates. Sine and cosine for all three angles come
// from three lanes of a chain of NCELLS cells (CORDIC_STAGES, capped at
// ATAN_LEN) started at the gain-compensated constant, with a quarter-turn
// fold (angles beyond a quarter turn are shifted by pi and the result
// negated; -32768 gives cos -1, sin 0). The three axis rotations follow as
// a row of 3-stage units, each with exact split products rounded at
// INTERNAL_FRAC_BITS. The block takes one transaction per clock cycle while
// in_ready_o is high; a result passes through the input register, the cell
// chain, the fold register, the three rotation units, the rounding register
// and the output register. That register, backed by a one-entry skid stage,
// lets a new transaction in while a finished result waits; in_ready_o
// drops only while the skid stage holds a result, and rises again the cycle
// after the output is taken. The block keeps no state between transactions.
module euler_xyz_vector_rotator_core #(
  parameter int CORDIC_STAGES      = ezr_pkg::CORDIC_STAGES_DEF,
  parameter int INTERNAL_FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ezr_pkg::IN_W-1:0]   vec_x_i,
  input  logic signed [ezr_pkg::IN_W-1:0]   vec_y_i,
  input  logic signed [ezr_pkg::IN_W-1:0]   vec_z_i,
  input  logic signed [ezr_pkg::IN_W-1:0]   angle_x_i,
  input  logic signed [ezr_pkg::IN_W-1:0]   angle_y_i,
  input  logic signed [ezr_pkg::IN_W-1:0]   angle_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ezr_pkg::OUT_W-1:0]  out_x_o,
  output logic signed [ezr_pkg::OUT_W-1:0]  out_y_o,
  output logic signed [ezr_pkg::OUT_W-1:0]  out_z_o
);

  import ezr_pkg::*;

  localparam int F      = INTERNAL_FRAC_BITS;
  localparam int NCELLS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int CW     = F + 2;          // sine/cosine width
  localparam int VW     = F + VEC_INT_W;  // vector component width
  localparam int LAT    = NCELLS + 12;    // register stages up to the last one
  localparam int NAX    = 3;

  // CORDIC start value K, gain compensated, in QF.
  localparam longint unsigned GAIN_ROOT = gain_root(NCELLS);
  localparam longint unsigned GAIN_Q30  = (64'd1 << 60) / GAIN_ROOT;
  localparam longint unsigned GAIN_QFL  = (GAIN_Q30 + (64'd1 << (29 - F))) >> (30 - F);
  localparam logic signed [CW-1:0] GAIN_QF = CW'(GAIN_QFL);

  localparam logic signed [IN_W-1:0] QUARTER_POS = 16'sd16384;
  localparam logic signed [IN_W-1:0] QUARTER_NEG = -16'sd16384;

  // ---------------------------------------------------------------------
  // Flow control: all stages advance together unless the skid stage holds.
  // ---------------------------------------------------------------------
  logic en, in_acc;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;
  logic [LAT-1:0] vld_q;
  logic p_valid;
  logic load_out_skid, load_out_pipe, load_skid, out_free;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_acc};
    end
  end

  assign p_valid = vld_q[LAT-1];

  // ---------------------------------------------------------------------
  // Input register: vector and folded angles.
  // ---------------------------------------------------------------------
  logic signed [IN_W-1:0]  vx_q, vy_q, vz_q;
  logic signed [IN_W-1:0]  ang [NAX];
  logic signed [ANG_W-1:0] z_init_q [NAX];
  logic                    neg_q [NAX];

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q <= vec_x_i;
      vy_q <= vec_y_i;
      vz_q <= vec_z_i;
      for (int l = 0; l < NAX; l++) begin
        // Fold by pi beyond a quarter turn: flip the sign bit of angle*2^16.
        neg_q[l]    <= (ang[l] > QUARTER_POS) || (ang[l] < QUARTER_NEG);
        z_init_q[l] <= {ang[l][IN_W-1] ^ ((ang[l] > QUARTER_POS) || (ang[l] < QUARTER_NEG)),
                        ang[l][IN_W-2:0], {(ANG_W-IN_W){1'b0}}};
      end
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC cell chain, one lane per axis.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0]    cx [NCELLS+1][NAX];
  logic signed [CW-1:0]    cy [NCELLS+1][NAX];
  logic signed [ANG_W-1:0] cz [NCELLS+1][NAX];
  logic                    cn [NCELLS+1][NAX];

  for (genvar l = 0; l < NAX; l++) begin : g_lane
    assign cx[0][l] = GAIN_QF;
    assign cy[0][l] = '0;
    assign cz[0][l] = z_init_q[l];
    assign cn[0][l] = neg_q[l];
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
      ezr_cordic_cell #(
        .STAGE (g),
        .CW    (CW)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (cx[g][l]),
        .y_i   (cy[g][l]),
        .z_i   (cz[g][l]),
        .neg_i (cn[g][l]),
        .x_o   (cx[g+1][l]),
        .y_o   (cy[g+1][l]),
        .z_o   (cz[g+1][l]),
        .neg_o (cn[g+1][l])
      );
    end
  end

  // Undo the fold: negate cosine and sine together.
  logic signed [CW-1:0] cos_q [NAX];
  logic signed [CW-1:0] sin_q [NAX];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NAX; l++) begin
        cos_q[l] <= cn[NCELLS][l] ? -cx[NCELLS][l] : cx[NCELLS][l];
        sin_q[l] <= cn[NCELLS][l] ? -cy[NCELLS][l] : cy[NCELLS][l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Alignment of the vector and of later coefficients.
  // ---------------------------------------------------------------------
  logic [3*IN_W-1:0]      vec_dly;
  logic signed [IN_W-1:0] vx_a, vy_a, vz_a, vx_b;
  logic [2*CW-1:0]        csy_dly, csz_dly;
  logic signed [CW-1:0]   cos_y, sin_y, cos_z, sin_z;

  ezr_delay #(.W(3*IN_W), .DEPTH(NCELLS+1)) u_vec_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({vx_q, vy_q, vz_q}),
    .q_o   (vec_dly)
  );

  assign vx_a = vec_dly[3*IN_W-1:2*IN_W];
  assign vy_a = vec_dly[2*IN_W-1:IN_W];
  assign vz_a = vec_dly[IN_W-1:0];

  ezr_delay #(.W(IN_W), .DEPTH(3)) u_vx_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (vx_a),
    .q_o   (vx_b)
  );

  ezr_delay #(.W(2*CW), .DEPTH(3)) u_csy_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({cos_q[1], sin_q[1]}),
    .q_o   (csy_dly)
  );

  ezr_delay #(.W(2*CW), .DEPTH(6)) u_csz_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({cos_q[2], sin_q[2]}),
    .q_o   (csz_dly)
  );

  assign cos_y = csy_dly[2*CW-1:CW];
  assign sin_y = csy_dly[CW-1:0];
  assign cos_z = csz_dly[2*CW-1:CW];
  assign sin_z = csz_dly[CW-1:0];

  // ---------------------------------------------------------------------
  // Axis rotations: x, then y, then z.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] y1, z1, z2, x2, x3, y3, y1_d, z2_d;
  logic signed [VW-1:0] vy_f, vz_f, vx_f;

  assign vy_f = {{(VEC_INT_W-IN_W){vy_a[IN_W-1]}}, vy_a, {F{1'b0}}};
  assign vz_f = {{(VEC_INT_W-IN_W){vz_a[IN_W-1]}}, vz_a, {F{1'b0}}};
  assign vx_f = {{(VEC_INT_W-IN_W){vx_b[IN_W-1]}}, vx_b, {F{1'b0}}};

  // Rx: y' = c*y - s*z, z' = s*y + c*z
  ezr_rot_unit #(.FRAC(F), .CW(CW)) u_rot_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (vy_f),
    .b_i   (vz_f),
    .c_i   (cos_q[0]),
    .s_i   (sin_q[0]),
    .u_o   (y1),
    .w_o   (z1)
  );

  // Ry: z' = c*z - s*x, x' = s*z + c*x
  ezr_rot_unit #(.FRAC(F), .CW(CW)) u_rot_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (z1),
    .b_i   (vx_f),
    .c_i   (cos_y),
    .s_i   (sin_y),
    .u_o   (z2),
    .w_o   (x2)
  );

  ezr_delay #(.W(VW), .DEPTH(3)) u_y1_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (y1),
    .q_o   (y1_d)
  );

  // Rz: x' = c*x - s*y, y' = s*x + c*y
  ezr_rot_unit #(.FRAC(F), .CW(CW)) u_rot_z (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (x2),
    .b_i   (y1_d),
    .c_i   (cos_z),
    .s_i   (sin_z),
    .u_o   (x3),
    .w_o   (y3)
  );

  ezr_delay #(.W(VW), .DEPTH(3)) u_z2_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (z2),
    .q_o   (z2_d)
  );

  // ---------------------------------------------------------------------
  // Round half up to integers.
  // ---------------------------------------------------------------------
  localparam longint HALF_L = 64'sd1 <<< (F - 1);
  localparam logic signed [VW:0] HALF = (VW+1)'(HALF_L);

  logic signed [VW:0]    rx_sum, ry_sum, rz_sum;
  logic signed [OUT_W-1:0] px_q, py_q, pz_q;

  assign rx_sum = (VW+1)'(x3) + HALF;
  assign ry_sum = (VW+1)'(y3) + HALF;
  assign rz_sum = (VW+1)'(z2_d) + HALF;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= rx_sum[F+OUT_W-1:F];
      py_q <= ry_sum[F+OUT_W-1:F];
      pz_q <= rz_sum[F+OUT_W-1:F];
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid stage.
  // ---------------------------------------------------------------------
  logic signed [OUT_W-1:0] ox_q, oy_q, oz_q, sx_q, sy_q, sz_q;

  assign out_free      = ~out_valid_q | out_ready_i;
  assign load_out_skid = skid_valid_q & out_free;
  assign load_out_pipe = ~skid_valid_q & p_valid & out_free;
  assign load_skid     = ~skid_valid_q & p_valid & ~out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out_skid || load_out_pipe) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    skid_valid_d = skid_valid_q;
    if (load_skid) begin
      skid_valid_d = 1'b1;
    end else if (load_out_skid) begin
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      ox_q <= sx_q;
      oy_q <= sy_q;
      oz_q <= sz_q;
    end else if (load_out_pipe) begin
      ox_q <= px_q;
      oy_q <= py_q;
      oz_q <= pz_q;
    end
    if (load_skid) begin
      sx_q <= px_q;
      sy_q <= py_q;
      sz_q <= pz_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;

endmodule

// File: hdl/ezr_checker.sv
// Port-level checks for the Euler XYZ vector rotator and their bind to the
// top level. Depends on euler_xyz_vector_rotator_core and ezr_pkg.
module ezr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [ezr_pkg::OUT_W-1:0] out_x_o,
  input logic signed [ezr_pkg::OUT_W-1:0] out_y_o,
  input logic signed [ezr_pkg::OUT_W-1:0] out_z_o
);

  import ezr_pkg::*;

  // Input side holds back only while a result sits at the output.
  a_ready_low_needs_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o
  ) else $error("in_ready_o low without a pending result");

  // Ready drops only after the output stalled.
  a_ready_fall_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i)
  ) else $error("in_ready_o fell without an output stall");

  // Taking the output frees the input side on the next cycle.
  a_ready_recovers: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && out_ready_i) |=> in_ready_o
  ) else $error("in_ready_o did not recover after output taken");

  // A stalled result holds.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o))
  ) else $error("stalled output transaction changed");

endmodule

bind euler_xyz_vector_rotator_core ezr_checker u_ezr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o)
);

// File: tb/sv/tb_euler_xyz_vector_rotator_core.sv
// Self-checking testbench for euler_xyz_vector_rotator_core: directed table plus
// random transactions, checked against an in-bench fixed-point CORDIC predictor.
// Depends on ezr_pkg and the RTL of the rotator core.
module tb_euler_xyz_vector_rotator_core;

  import ezr_pkg::*;

  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int USED_STG  = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
  localparam int LATENCY   = STAGES + 12;
  localparam int STALL_MAX = 3000;
  localparam int HOLD_LEN  = 300;
  localparam int N_RANDOM  = 400;
  localparam int MAX_SHOWN = 10;

  // Corner values of a 16-bit field; Q_* sit around the quarter-turn fold.
  localparam logic signed [IN_W-1:0] S_MAX  = 16'sh7FFF;
  localparam logic signed [IN_W-1:0] S_MIN  = 16'sh8000;
  localparam logic signed [IN_W-1:0] S_ZERO = 16'sh0000;
  localparam logic signed [IN_W-1:0] S_ONE  = 16'sh0001;
  localparam logic signed [IN_W-1:0] S_M1   = 16'shFFFF;
  localparam logic signed [IN_W-1:0] Q_POS  = 16'sh4000;
  localparam logic signed [IN_W-1:0] Q_POS1 = 16'sh4001;
  localparam logic signed [IN_W-1:0] Q_NEG  = 16'shC000;
  localparam logic signed [IN_W-1:0] Q_NEG1 = 16'shBFFF;

  typedef struct packed {
    logic signed [IN_W-1:0] vx, vy, vz, ax, ay, az;
  } rot_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rx, ry, rz;
  } rot_res_t;

  typedef struct packed {
    rot_req_t req;
    logic     typed;
    rot_res_t res;
  } dir_row_t;

  localparam rot_res_t RES_ZERO = '{18'sd0, 18'sd0, 18'sd0};

  // Arctangent of 2^-i, pi = 2^31.
  localparam longint ATAN_RAD [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Directed table. Only the zero vector has an answer readable at a glance;
  // every other row goes through the predictor.
  localparam int NDIR = 22;
  localparam dir_row_t DIRECTED [NDIR] = '{
    '{'{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1'b1, RES_ZERO},
    '{'{S_ZERO, S_ZERO, S_ZERO, S_MIN,  S_MIN,  S_MIN }, 1'b1, RES_ZERO},
    '{'{S_ZERO, S_ZERO, S_ZERO, S_MAX,  Q_POS,  Q_NEG }, 1'b1, RES_ZERO},
    '{'{S_MAX,  S_MAX,  S_MAX,  S_ZERO, S_ZERO, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_MIN,  S_MIN,  S_MIN,  S_ZERO, S_ZERO, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_MIN,  S_MIN,  S_MIN,  S_MIN,  S_MIN,  S_MIN }, 1'b0, RES_ZERO},
    '{'{S_MAX,  S_ZERO, S_ZERO, S_ZERO, S_ZERO, Q_POS }, 1'b0, RES_ZERO},
    '{'{S_MAX,  S_ZERO, S_ZERO, S_ZERO, S_ZERO, Q_POS1}, 1'b0, RES_ZERO},
    '{'{S_ZERO, S_MAX,  S_ZERO, Q_NEG,  S_ZERO, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_ZERO, S_MAX,  S_ZERO, Q_NEG1, S_ZERO, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_ZERO, S_ZERO, S_MAX,  S_ZERO, Q_POS,  S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_ZERO, S_ZERO, S_MAX,  S_ZERO, Q_POS1, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_MIN,  S_MAX,  S_MIN,  S_ZERO, Q_NEG1, S_ZERO}, 1'b0, RES_ZERO},
    '{'{S_ONE,  S_M1,   S_ONE,  S_MAX,  S_MAX,  S_MAX }, 1'b0, RES_ZERO},
    '{'{S_M1,   S_M1,   S_M1,   S_ONE,  S_M1,   S_ONE }, 1'b0, RES_ZERO},
    '{'{S_MIN,  S_MIN,  S_MIN,  S_MAX,  Q_POS,  Q_NEG1}, 1'b0, RES_ZERO},
    '{'{S_MAX,  S_MIN,  S_MAX,  Q_POS1, Q_NEG,  S_MIN }, 1'b0, RES_ZERO},
    '{'{S_MAX,  S_MAX,  S_MAX,  Q_POS,  Q_POS,  Q_POS }, 1'b0, RES_ZERO},
    '{'{S_MIN,  S_ZERO, S_MAX,  S_MIN,  S_ZERO, Q_POS }, 1'b0, RES_ZERO},
    '{'{16'sh1234, 16'shA5A5, 16'sh7F00, 16'sh2000, 16'shE000, 16'sh2000},
      1'b0, RES_ZERO},
    '{'{16'sh5A5A, 16'shA5A5, 16'sh0F0F, 16'sh7000, 16'sh9000, 16'sh2000},
      1'b0, RES_ZERO},
    '{'{S_MAX,  S_MAX,  S_MIN,  S_MIN,  Q_NEG,  Q_POS1}, 1'b0, RES_ZERO}
  };

  // DUT-facing signals; the inputs are driven to known values from time zero.
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [IN_W-1:0]  vec_x     = '0;
  logic signed [IN_W-1:0]  vec_y     = '0;
  logic signed [IN_W-1:0]  vec_z     = '0;
  logic signed [IN_W-1:0]  angle_x   = '0;
  logic signed [IN_W-1:0]  angle_y   = '0;
  logic signed [IN_W-1:0]  angle_z   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;

  // Bench state.
  longint   cordic_k;          // gain-compensated CORDIC start value in QF
  rot_res_t rotated_q [$];     // expected rotated vectors, oldest first
  int       mismatch_cnt = 0;
  int       stall_cycles = 0;
  int       in_idle_pct  = 0;
  int       out_idle_pct = 0;
  int       hold_req     = 0;
  int       hold_left    = 0;

  euler_xyz_vector_rotator_core #(
    .CORDIC_STAGES      (STAGES),
    .INTERNAL_FRAC_BITS (FRAC)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .vec_z_i     (vec_z),
    .angle_x_i   (angle_x),
    .angle_y_i   (angle_y),
    .angle_z_i   (angle_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z)
  );

  // 20-unit clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sine and cosine of a binary angle in QF. Fold angles past a quarter turn
  // by pi and negate the CORDIC outputs; -32768 folds to zero, giving -1 / 0.
  function automatic void cordic_sincos(input logic signed [IN_W-1:0] ang,
                                        output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z    = longint'(ang) * 65536;
    x    = cordic_k;
    y    = 0;
    flip = 1'b0;
    if (ang > Q_POS) begin
      z    = z - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (ang < Q_NEG) begin
      z    = z + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int i = 0; i < USED_STG; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_RAD[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_RAD[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // (p*a + q*b) / 2^F rounded half up; the full product fits 64 bits here.
  function automatic longint round_dot2(input longint p, input longint a,
                                        input longint q, input longint b);
    return (p * a + q * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Rz * Ry * Rx * v, each component rounded half up to an 18-bit integer.
  function automatic rot_res_t rotate_xyz(input rot_req_t r);
    longint   x;
    longint   y;
    longint   z;
    longint   c;
    longint   s;
    longint   t;
    rot_res_t o;
    x = longint'($signed(r.vx)) <<< FRAC;
    y = longint'($signed(r.vy)) <<< FRAC;
    z = longint'($signed(r.vz)) <<< FRAC;

    cordic_sincos(r.ax, c, s);
    t = round_dot2(c, y, -s, z);
    z = round_dot2(s, y, c, z);
    y = t;

    cordic_sincos(r.ay, c, s);
    t = round_dot2(c, x, s, z);
    z = round_dot2(-s, x, c, z);
    x = t;

    cordic_sincos(r.az, c, s);
    t = round_dot2(c, x, -s, y);
    y = round_dot2(s, x, c, y);
    x = t;

    t    = (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    o.rx = t[OUT_W-1:0];
    t    = (y + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    o.ry = t[OUT_W-1:0];
    t    = (z + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    o.rz = t[OUT_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly full-range random; one field in four lands on a corner value.
  function automatic logic signed [IN_W-1:0] pick_field();
    logic [31:0] raw;
    raw = $urandom();
    if ($urandom_range(3) != 0) begin
      return raw[IN_W-1:0];
    end
    case ($urandom_range(8))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return S_ZERO;
      3:       return S_ONE;
      4:       return S_M1;
      5:       return Q_POS;
      6:       return Q_POS1;
      7:       return Q_NEG;
      default: return Q_NEG1;
    endcase
  endfunction

  // Offer one transaction. Enter and leave at a falling edge; insert random
  // idle cycles first, then hold valid and payload until accepted.
  task automatic send_rotation(input rot_req_t r, input logic typed,
                               input rot_res_t typed_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    vec_x    = r.vx;
    vec_y    = r.vy;
    vec_z    = r.vz;
    angle_x  = r.ax;
    angle_y  = r.ay;
    angle_z  = r.az;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: record what must come out.
    rotated_q.push_back(typed ? typed_res : rotate_xyz(r));
    @(negedge clk);
  endtask

  task automatic run_random(input int n_items, input int hold);
    rot_req_t r;
    if (hold > 0) begin
      hold_req = hold;
    end
    for (int n = 0; n < n_items; n++) begin
      r.vx = pick_field();
      r.vy = pick_field();
      r.vz = pick_field();
      r.ax = pick_field();
      r.ay = pick_field();
      r.az = pick_field();
      send_rotation(r, 1'b0, RES_ZERO);
    end
    in_valid = 1'b0;
    // Hold the sender until the block has drained.
    while (rotated_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= MAX_SHOWN) begin
          $display("unexpected result: x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        end
      end else begin
        want = rotated_q.pop_front();
        if (out_x !== want.rx || out_y !== want.ry || out_z !== want.rz) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MAX_SHOWN) begin
            $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     want.rx, want.ry, want.rz, out_x, out_y, out_z);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("euler_xyz_vector_rotator_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    longint unsigned p;
    longint unsigned v;
    longint unsigned root;
    longint unsigned bt;
    longint unsigned k;

    // Derive the CORDIC start value: 1 / sqrt(prod(1 + 4^-i)) in QF.
    p = 64'd1 << 30;
    for (int i = 0; i < USED_STG; i++) begin
      p = p + (p >> (2 * i));
    end
    v    = p << 30;
    root = 0;
    bt   = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= root + bt) begin
        v    = v - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    k        = (64'd1 << 60) / root;
    cordic_k = longint'((k + (64'd1 << (29 - FRAC))) >> (30 - FRAC));

    // Hold reset, then release it at a falling edge.
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table under light input and heavy output idling.
    in_idle_pct  = 12;
    out_idle_pct = 79;
    for (int d = 0; d < NDIR; d++) begin
      send_rotation(DIRECTED[d].req, DIRECTED[d].typed, DIRECTED[d].res);
    end

    // Random phases: swap the idling, then run flat out with one long hold-off
    // so the pipeline fills and the input stalls.
    run_random(N_RANDOM, 0);
    in_idle_pct  = 79;
    out_idle_pct = 12;
    run_random(N_RANDOM, 0);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(N_RANDOM, HOLD_LEN);

    // Let any stray result show up before the verdict.
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && rotated_q.size() == 0) begin
      $display("euler_xyz_vector_rotator_core regression: pass");
    end else begin
      $display("euler_xyz_vector_rotator_core regression: fail");
    end
    $finish;
  end

endmodule
